>>> hdl/bxavg_pkg.sv
// ----------------------------------------------------------------------------
// bxavg_pkg
// Shared types and constants for the 2x2 box-average downsampler.
// ----------------------------------------------------------------------------
package bxavg_pkg;

    // Widest input row the line store is sized for
    localparam int BXAVG_MAX_WIDTH = 2048;
    // Tallest frame the row counter covers
    localparam int MAX_HEIGHT      = 2048;

    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 2;
    localparam int SHIFT_W     = 2;
    localparam int ROW_W       = 11;
    localparam int PIX_W       = 8;
    localparam int PAIR_W      = PIX_W + 1;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SHIFT        = 2'd2;

    // Per-pixel action codes
    localparam logic [1:0] OP_NONE = 2'd0;  // pixel outside any block corner
    localparam logic [1:0] OP_HOLD = 2'd1;  // left pixel of a corner pair
    localparam logic [1:0] OP_PAIR = 2'd2;  // right pixel of the top pair
    localparam logic [1:0] OP_EMIT = 2'd3;  // right pixel of the bottom pair

    typedef struct packed {
        logic [CFG_DATA_W-1:0] width;
        logic [CFG_DATA_W-1:0] height;
        logic [SHIFT_W-1:0]    shift;
    } cfg_t;

    typedef struct packed {
        logic [1:0] op;
        logic       last;
    } scan_ctl_t;

endpackage

>>> hdl/bxavg_scan.sv
// ----------------------------------------------------------------------------
// bxavg_scan
// Raster position counters and per-pixel decode of the block corner role.
// ----------------------------------------------------------------------------
module bxavg_scan #(
    parameter int MAX_WIDTH = bxavg_pkg::BXAVG_MAX_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bxavg_pkg::cfg_t                      cfg,
    input  logic                                 advance,
    output bxavg_pkg::scan_ctl_t                 ctl,
    output logic [$clog2(MAX_WIDTH/2)-1:0]       idx
);
    import bxavg_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int AW = $clog2(MAX_WIDTH / 2);
    localparam int HW = ROW_W + 1;

    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic [WW-1:0]      w_eff, w2;
    logic [HW-1:0]      h_eff, h2;
    logic [SHIFT_W-1:0] s_eff;
    logic [3:0]         mask4;
    logic [CW-1:0]      ox, dc;
    logic [ROW_W-1:0]   oy, dr;
    logic               in_block;

    // Saturate the geometry registers to their legal ranges
    always_comb
    begin
        if (cfg.width < CFG_DATA_W'(2))
            w_eff = WW'(2);
        else if (32'(cfg.width) > 32'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(cfg.width);

        if (cfg.height < CFG_DATA_W'(2))
            h_eff = HW'(2);
        else if (32'(cfg.height) > 32'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = cfg.height;

        s_eff = (cfg.shift == '0) ? SHIFT_W'(1) : cfg.shift;
    end

    assign mask4 = (4'd1 << s_eff) - 4'd1;
    assign w2    = w_eff >> s_eff;
    assign h2    = h_eff >> s_eff;
    assign ox    = col_reg >> s_eff;
    assign oy    = row_reg >> s_eff;
    assign dc    = col_reg & CW'(mask4);
    assign dr    = row_reg & ROW_W'(mask4);

    assign in_block = ({1'b0, col_reg} < w_eff) && ({1'b0, row_reg} < h_eff)
                   && ({1'b0, ox} < w2) && ({1'b0, oy} < h2);

    always_comb
    begin
        ctl.op = OP_NONE;
        if (in_block && (dr == ROW_W'(0) || dr == ROW_W'(1)))
        begin
            if (dc == CW'(0))
                ctl.op = OP_HOLD;
            else if (dc == CW'(1))
                ctl.op = (dr == ROW_W'(0)) ? OP_PAIR : OP_EMIT;
        end
        ctl.last = ({1'b0, ox} == w2 - WW'(1)) && ({1'b0, oy} == h2 - HW'(1));
    end

    assign idx = ox[AW-1:0];

    // Wrap at the row end and at the frame end
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance)
        begin
            if ({1'b0, col_reg} + WW'(1) >= w_eff)
            begin
                col_next = '0;
                if ({1'b0, row_reg} + HW'(1) >= h_eff)
                    row_next = '0;
                else
                    row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

>>> hdl/bxavg_line_ram.sv
// ----------------------------------------------------------------------------
// bxavg_line_ram
// Line store of top-pair sums, one entry per output column; registered read.
// ----------------------------------------------------------------------------
module bxavg_line_ram #(
    parameter int MAX_WIDTH = bxavg_pkg::BXAVG_MAX_WIDTH
) (
    input  logic                                clk,
    input  logic                                rd_en,
    input  logic [$clog2(MAX_WIDTH/2)-1:0]      rd_addr,
    output logic [bxavg_pkg::PAIR_W-1:0]        rd_data,
    input  logic                                wr_en,
    input  logic [$clog2(MAX_WIDTH/2)-1:0]      wr_addr,
    input  logic [bxavg_pkg::PAIR_W-1:0]        wr_data
);
    import bxavg_pkg::*;

    localparam int DEPTH = MAX_WIDTH / 2;

    logic [PAIR_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

>>> hdl/box_average_downsampler.sv
// ----------------------------------------------------------------------------
// box_average_downsampler
// Streaming image reducer: one 8-bit luma pixel per transfer in raster order,
// one output pixel per 2^shift x 2^shift block (shift 0 acts as 1), the floor average of the
// block's top-left 2x2 corner.
// ----------------------------------------------------------------------------
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  input   | in_valid, in_stall, pixel                  | in
//  output  | out_valid, out_stall, avg_pixel, frame_last| out
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data  | in
//
//  One pixel transfer per cycle sustained unless a result waits on a stalled
//  output. An accepted pixel's result passes the decode register, then the
//  result register. The line store read is issued when the pixel is taken.
//  Reset clears the position counters, the held pixel, both stage valids and
//  loads the geometry registers with 2048 x 2048, shift 2. The line store is
//  not cleared. Only a result waiting on a stalled output holds the decode
//  stage; pixels that produce no result keep flowing.
//
module box_average_downsampler #(
    parameter int MAX_WIDTH = bxavg_pkg::BXAVG_MAX_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // pixel input
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [bxavg_pkg::PIX_W-1:0]          pixel,
    // result output
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [bxavg_pkg::PIX_W-1:0]          avg_pixel,
    output logic                                 frame_last,
    // register writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bxavg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bxavg_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bxavg_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH / 2);

    // Geometry registers
    cfg_t cfg_reg, cfg_next;

    // Decode stage
    logic              s1_valid_reg, s1_valid_next;
    logic [PIX_W-1:0]  s1_pixel_reg;
    scan_ctl_t         s1_ctl_reg;
    logic [AW-1:0]     s1_idx_reg;

    // Corner pair state
    logic [PIX_W-1:0]  held_reg, held_next;

    // Result register
    logic              out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]  avg_reg, avg_next;
    logic              last_reg, last_next;

    logic              accept;
    logic              s1_go;
    logic              out_free;
    scan_ctl_t         scan_ctl;
    logic [AW-1:0]     scan_idx;
    logic [PAIR_W-1:0] line_rd;
    logic [PAIR_W-1:0] pair_sum;
    logic [PIX_W+1:0]  box_sum;
    logic              line_we;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_next.width  = cfg_data;
                REG_IMAGE_HEIGHT: cfg_next.height = cfg_data;
                REG_SHIFT:        cfg_next.shift  = cfg_data[SHIFT_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // ---------------- handshake ----------------
    // Output register frees up when empty or when its transfer completes.
    assign out_free = !out_valid_reg || !out_stall;
    // Only a result-producing pixel needs room downstream.
    assign s1_go    = s1_valid_reg && ((s1_ctl_reg.op != OP_EMIT) || out_free);
    assign in_stall = s1_valid_reg && !s1_go;
    assign accept   = in_valid && !in_stall;

    // ---------------- position decode ----------------
    bxavg_scan #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .advance (accept),
        .ctl     (scan_ctl),
        .idx     (scan_idx)
    );

    // ---------------- line store ----------------
    // Read is launched with the transfer, so data sits next to the decode
    // stage. A top-pair write always lands at least one pixel ahead of the
    // bottom-pair read of the same column.
    assign pair_sum = PAIR_W'(held_reg) + PAIR_W'(s1_pixel_reg);
    assign line_we  = s1_go && (s1_ctl_reg.op == OP_PAIR);

    bxavg_line_ram #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (scan_idx),
        .rd_data (line_rd),
        .wr_en   (line_we),
        .wr_addr (s1_idx_reg),
        .wr_data (pair_sum)
    );

    // ---------------- corner arithmetic ----------------
    assign box_sum = (PIX_W+2)'(line_rd) + (PIX_W+2)'(held_reg)
                   + (PIX_W+2)'(s1_pixel_reg);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;

        held_next = held_reg;
        if (s1_go && (s1_ctl_reg.op == OP_HOLD))
            held_next = s1_pixel_reg;

        out_valid_next = out_valid_reg;
        avg_next       = avg_reg;
        last_next      = last_reg;
        if (s1_go && (s1_ctl_reg.op == OP_EMIT))
        begin
            out_valid_next = 1'b1;
            avg_next       = box_sum[PIX_W+1:2];  // floor of sum / 4
            last_next      = s1_ctl_reg.last;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= CFG_DATA_W'(2048);
            cfg_reg.height <= CFG_DATA_W'(2048);
            cfg_reg.shift  <= SHIFT_W'(2);
            s1_valid_reg   <= 1'b0;
            held_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            s1_valid_reg  <= s1_valid_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pixel;
            s1_ctl_reg   <= scan_ctl;
            s1_idx_reg   <= scan_idx;
        end
        avg_reg  <= avg_next;
        last_reg <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign avg_pixel  = avg_reg;
    assign frame_last = last_reg;

endmodule
